FILE: hdl/bpa_pkg.sv
package bpa_pkg;

    localparam int LEVELS    = 10;
    localparam int TOP_ORDER = LEVELS - 1;
    localparam int NPAGES    = 1 << LEVELS;
    localparam int IDX_W     = LEVELS;
    localparam int POS_W     = LEVELS + 1;
    localparam int ORD_W     = 4;
    localparam int N_W       = LEVELS - 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int NWORDS    = NPAGES / WORD_W;
    localparam int WSEL_W    = LEVELS - BIT_W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic SEL_USED = 1'b0;
    localparam logic SEL_PAIR = 1'b1;

    // One request to the bitmap unit: find the first set bit, or flip all
    // bits, over the bit range [lo, hi) of one of the two maps.
    typedef struct packed {
        logic             start;
        logic             sel;
        logic             flip;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } scan_req_t;

    typedef struct packed {
        logic             ready;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] pos;
    } scan_rsp_t;

    // First pair bit of an order inside the pair map.
    function automatic logic [POS_W-1:0] pair_base(input logic [ORD_W-1:0] ord);
        pair_base = POS_W'(NPAGES) - (POS_W'(NPAGES) >> ord);
    endfunction

    function automatic logic [POS_W-1:0] pair_pos(input logic [ORD_W-1:0] ord,
                                                  input logic [N_W-1:0] n);
        pair_pos = {1'b0, IDX_W'(pair_base(ord) + POS_W'(n))};
    endfunction

    function automatic logic [POS_W-1:0] span(input logic [ORD_W-1:0] ord);
        span = POS_W'(1) << ord;
    endfunction

endpackage

FILE: hdl/bpa_bitmap.sv
module bpa_bitmap (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpa_pkg::scan_req_t  req,
    output bpa_pkg::scan_rsp_t  rsp
);
    import bpa_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC} state_t;

    state_t             state_reg;
    logic [WSEL_W-1:0]  word_reg;
    logic               sel_reg;
    logic               flip_reg;
    logic [POS_W-1:0]   lo_reg;
    logic [POS_W-1:0]   hi_reg;
    logic               done_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   pos_reg;

    logic [WORD_W-1:0]  used_mem [NWORDS];
    logic [WORD_W-1:0]  pair_mem [NWORDS];
    logic [WORD_W-1:0]  used_rd_reg;
    logic [WORD_W-1:0]  pair_rd_reg;

    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  hit;
    logic [BIT_W-1:0]   first;
    logic               last_word;
    logic               used_we;
    logic               pair_we;
    logic [WORD_W-1:0]  wr_data;
    logic [POS_W-1:0]   bit_pos;

    assign rd_word = (sel_reg == SEL_PAIR) ? pair_rd_reg : used_rd_reg;

    always_comb begin
        mask = '0;
        for (int i = 0; i < WORD_W; i++) begin
            bit_pos = {1'b0, word_reg, BIT_W'(i)};
            mask[i] = (bit_pos >= lo_reg) && (bit_pos < hi_reg);
        end
    end

    assign hit = rd_word & mask;

    always_comb begin
        first = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (hit[i]) begin
                first = BIT_W'(i);
            end
        end
    end

    assign last_word = ({1'b0, word_reg, {BIT_W{1'b1}}} + POS_W'(1)) >= hi_reg;

    always_comb begin
        used_we = 1'b0;
        pair_we = 1'b0;
        wr_data = rd_word ^ mask;
        if (state_reg == S_CLEAR) begin
            used_we = 1'b1;
            pair_we = 1'b1;
            wr_data = '0;
        end else if (state_reg == S_EXEC && flip_reg) begin
            used_we = (sel_reg == SEL_USED);
            pair_we = (sel_reg == SEL_PAIR);
        end
    end

    // Both maps are word memories; the word under work is read every cycle.
    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[word_reg] <= wr_data;
        end
        if (pair_we) begin
            pair_mem[word_reg] <= wr_data;
        end
        used_rd_reg <= used_mem[word_reg];
        pair_rd_reg <= pair_mem[word_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            word_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    done_reg <= 1'b0;
                    word_reg <= word_reg + WSEL_W'(1);
                    if (word_reg == WSEL_W'(NWORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    done_reg <= 1'b0;
                    if (req.start) begin
                        sel_reg   <= req.sel;
                        flip_reg  <= req.flip;
                        lo_reg    <= req.lo;
                        hi_reg    <= req.hi;
                        word_reg  <= req.lo[IDX_W-1:BIT_W];
                        found_reg <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    done_reg  <= 1'b0;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    if (!flip_reg && hit != '0) begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b1;
                        pos_reg   <= {word_reg, first};
                        state_reg <= S_IDLE;
                    end else if (last_word) begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        done_reg  <= 1'b0;
                        word_reg  <= word_reg + WSEL_W'(1);
                        state_reg <= S_READ;
                    end
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.ready = (state_reg == S_IDLE);
    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.pos   = pos_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("bitmap done held longer than one cycle");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && found_reg |-> ({1'b0, pos_reg} >= lo_reg) && ({1'b0, pos_reg} < hi_reg))
        else $error("found bit lies outside the requested range");

    a_no_done_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !done_reg)
        else $error("bitmap reported completion during the clearing pass");

endmodule

FILE: hdl/buddy_page_allocator.sv
// Every bitmap access goes through the one shared word unit, which walks its range by 32-bit
// words, so time grows with the words scanned: the free-pair search and the page range flip.
// Throughput: one transaction at a time; s_ready is low while a request is in work.
// Reset: synchronous, active low; a pass over all 32 words then clears both bitmaps, and
// s_ready stays low until it ends.
module buddy_page_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [bpa_pkg::ORD_W-1:0]   s_order,
    input  logic [bpa_pkg::IDX_W-1:0]   s_block_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [bpa_pkg::IDX_W-1:0]   m_page_index
);
    import bpa_pkg::*;

    // The sequencer walks the buddy tree. Every bitmap access is a call to the
    // shared word unit: the calling state launches it, then waits for done and
    // consumes the answer, using pend_reg to tell the two phases apart.
    typedef enum logic [3:0] {
        S_IDLE, A_SRCH, A_TOP0, A_TOP1, A_SIDE, A_PFLIP, A_SPLIT, A_SIDE2,
        A_RFLIP, F_FLIP, F_COAL, F_CFLIP, F_LAST, S_DONE
    } state_t;

    state_t             state_reg;
    logic               pend_reg;
    scan_req_t          req_reg;
    scan_rsp_t          rsp;
    logic [ORD_W-1:0]   ord_reg;
    logic [ORD_W-1:0]   want_reg;
    logic [N_W-1:0]     n_reg;
    logic               side_reg;
    logic [IDX_W-1:0]   block_reg;
    logic [1:0]         res_status_reg;
    logic [IDX_W-1:0]   res_page_reg;
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [IDX_W-1:0]   m_page_reg;

    // Fields of the call that the current state makes.
    logic               call_en;
    logic               call_sel;
    logic               call_flip;
    logic [POS_W-1:0]   call_lo;
    logic [POS_W-1:0]   call_hi;
    logic [IDX_W-1:0]   alloc_page;
    logic [POS_W-1:0]   left_base;
    logic               at_top;

    assign at_top     = (ord_reg == ORD_W'(TOP_ORDER));
    assign alloc_page = IDX_W'({n_reg, side_reg} << ord_reg);
    assign left_base  = {1'b0, IDX_W'({n_reg, 1'b0} << ord_reg)};

    always_comb begin
        call_en   = 1'b0;
        call_sel  = SEL_USED;
        call_flip = 1'b0;
        call_lo   = '0;
        call_hi   = '0;
        case (state_reg)
            A_SRCH: begin
                // Below the top order, look for any set pair bit of this order.
                call_en  = !at_top;
                call_sel = SEL_PAIR;
                call_lo  = pair_base(ord_reg);
                call_hi  = POS_W'(NPAGES) - (POS_W'(NPAGES / 2) >> ord_reg);
            end
            A_TOP0: begin
                call_en = 1'b1;
                call_lo = '0;
                call_hi = POS_W'(NPAGES / 2);
            end
            A_TOP1: begin
                call_en = 1'b1;
                call_lo = POS_W'(NPAGES / 2);
                call_hi = POS_W'(NPAGES);
            end
            A_SIDE, A_SIDE2: begin
                // The left buddy is free when no used bit is found in it.
                call_en = 1'b1;
                call_lo = left_base;
                call_hi = left_base + span(ord_reg);
            end
            A_PFLIP, A_SPLIT, F_CFLIP, F_LAST: begin
                call_en   = 1'b1;
                call_sel  = SEL_PAIR;
                call_flip = 1'b1;
                call_lo   = pair_pos(ord_reg, n_reg);
                call_hi   = pair_pos(ord_reg, n_reg) + POS_W'(1);
            end
            A_RFLIP: begin
                call_en   = 1'b1;
                call_flip = 1'b1;
                call_lo   = {1'b0, alloc_page};
                call_hi   = {1'b0, alloc_page} + span(ord_reg);
            end
            F_FLIP: begin
                call_en   = 1'b1;
                call_flip = 1'b1;
                call_lo   = {1'b0, block_reg};
                call_hi   = {1'b0, block_reg} + span(ord_reg);
            end
            F_COAL: begin
                call_en  = !at_top;
                call_sel = SEL_PAIR;
                call_lo  = pair_pos(ord_reg, n_reg);
                call_hi  = pair_pos(ord_reg, n_reg) + POS_W'(1);
            end
            default: call_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            req_reg.start <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_reg.start <= call_en && !pend_reg;
            if (call_en && !pend_reg) begin
                req_reg.sel   <= call_sel;
                req_reg.flip  <= call_flip;
                req_reg.lo    <= call_lo;
                req_reg.hi    <= call_hi;
                pend_reg      <= 1'b1;
            end else if (pend_reg && rsp.done) begin
                pend_reg <= 1'b0;
            end
            // The finishing state reloads the output register itself.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        ord_reg      <= s_order;
                        want_reg     <= s_order;
                        block_reg    <= s_block_index;
                        n_reg        <= N_W'(s_block_index >> (s_order + ORD_W'(1)));
                        res_page_reg <= '0;
                        if (s_command == CMD_ALLOC) begin
                            if (s_order >= ORD_W'(LEVELS)) begin
                                res_status_reg <= ST_NOSPACE;
                                state_reg      <= S_DONE;
                            end else begin
                                state_reg <= A_SRCH;
                            end
                        end else begin
                            if (s_order >= ORD_W'(LEVELS) ||
                                (s_block_index & ~(IDX_W'({IDX_W{1'b1}}) << s_order)) != '0)
                            begin
                                res_status_reg <= ST_MISALIGN;
                                state_reg      <= S_DONE;
                            end else begin
                                state_reg <= F_FLIP;
                            end
                        end
                    end
                end
                A_SRCH: begin
                    if (at_top) begin
                        state_reg <= A_TOP0;
                    end else if (pend_reg && rsp.done) begin
                        if (rsp.found) begin
                            n_reg     <= N_W'({1'b0, rsp.pos} - pair_base(ord_reg));
                            state_reg <= A_SIDE;
                        end else begin
                            ord_reg <= ord_reg + ORD_W'(1);
                        end
                    end
                end
                A_TOP0: begin
                    if (pend_reg && rsp.done) begin
                        n_reg     <= '0;
                        state_reg <= rsp.found ? A_TOP1 : A_SIDE;
                    end
                end
                A_TOP1: begin
                    if (pend_reg && rsp.done) begin
                        if (rsp.found) begin
                            res_status_reg <= ST_NOSPACE;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= A_SIDE;
                        end
                    end
                end
                A_SIDE: begin
                    if (pend_reg && rsp.done) begin
                        side_reg  <= rsp.found;
                        state_reg <= A_PFLIP;
                    end
                end
                A_PFLIP: begin
                    if (pend_reg && rsp.done) begin
                        if (ord_reg != want_reg) begin
                            ord_reg   <= ord_reg - ORD_W'(1);
                            n_reg     <= N_W'({n_reg, side_reg});
                            state_reg <= A_SPLIT;
                        end else begin
                            state_reg <= A_RFLIP;
                        end
                    end
                end
                A_SPLIT: begin
                    // Each split leaves the right child free and goes down the left one.
                    if (pend_reg && rsp.done) begin
                        if (want_reg < ord_reg) begin
                            n_reg   <= N_W'({n_reg, 1'b0});
                            ord_reg <= ord_reg - ORD_W'(1);
                        end else begin
                            state_reg <= A_SIDE2;
                        end
                    end
                end
                A_SIDE2: begin
                    if (pend_reg && rsp.done) begin
                        side_reg  <= rsp.found;
                        state_reg <= A_RFLIP;
                    end
                end
                A_RFLIP: begin
                    if (pend_reg && rsp.done) begin
                        res_status_reg <= ST_OK;
                        res_page_reg   <= alloc_page;
                        state_reg      <= S_DONE;
                    end
                end
                F_FLIP: begin
                    if (pend_reg && rsp.done) begin
                        state_reg <= F_COAL;
                    end
                end
                F_COAL: begin
                    // A set pair bit means the buddy is free as well: merge and climb.
                    if (at_top) begin
                        state_reg <= F_LAST;
                    end else if (pend_reg && rsp.done) begin
                        state_reg <= rsp.found ? F_CFLIP : F_LAST;
                    end
                end
                F_CFLIP: begin
                    if (pend_reg && rsp.done) begin
                        ord_reg   <= ord_reg + ORD_W'(1);
                        n_reg     <= n_reg >> 1;
                        state_reg <= F_COAL;
                    end
                end
                F_LAST: begin
                    if (pend_reg && rsp.done) begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The output register holds one finished transaction.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_page_reg   <= res_page_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    bpa_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign s_ready      = (state_reg == S_IDLE) && rsp.ready;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_page_index = m_page_reg;

    a_done_only_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> pend_reg)
        else $error("bitmap completion without an outstanding call");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a transaction was accepted");

    a_page_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_page_index != '0 |-> m_status == ST_OK)
        else $error("nonzero page index returned with an error status");

endmodule
